// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

  localparam int unsigned LANES        = 8;
  localparam int unsigned BUTTONS_DEF  = 8;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned THR_WORD_W   = 64;
  localparam int unsigned APB_DATA_W   = 64;
  localparam int unsigned APB_ADDR_W   = 5;

  localparam logic [MS_W-1:0]       DEBOUNCE_RST  = 16'd50;
  localparam logic [MS_W-1:0]       SHORT_MAX_RST = 16'd1000;
  localparam logic [THR_WORD_W-1:0] THR_RST       = '0;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SHORT_MAX = 2'd1,
    REG_THR_LO    = 2'd2,
    REG_THR_HI    = 2'd3
  } bpc_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [LANES-1:0]  button_levels;
  } bpc_in_t;

  typedef struct packed {
    logic [LANES-1:0] short_press_mask;
    logic [LANES-1:0] long_press_mask;
  } bpc_out_t;

  typedef struct packed {
    logic [MS_W-1:0]       debounce_time;
    logic [MS_W-1:0]       short_limit;
    logic [THR_WORD_W-1:0] long_thresholds_lo;
    logic [THR_WORD_W-1:0] long_thresholds_hi;
  } bpc_cfg_t;

endpackage

// ===== hdl/bpc_regs.sv =====
module bpc_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output bpc_pkg::bpc_cfg_t                 cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_q, cfg_d;
  bpc_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = bpc_reg_e'(paddr[APB_ADDR_W-1:3]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEBOUNCE:  cfg_d.debounce_time      = pwdata[MS_W-1:0];
        REG_SHORT_MAX: cfg_d.short_limit        = pwdata[MS_W-1:0];
        REG_THR_LO:    cfg_d.long_thresholds_lo = pwdata[THR_WORD_W-1:0];
        REG_THR_HI:    cfg_d.long_thresholds_hi = pwdata[THR_WORD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:  prdata = {{(APB_DATA_W-MS_W){1'b0}}, cfg_q.debounce_time};
      REG_SHORT_MAX: prdata = {{(APB_DATA_W-MS_W){1'b0}}, cfg_q.short_limit};
      REG_THR_LO:    prdata = cfg_q.long_thresholds_lo;
      REG_THR_HI:    prdata = cfg_q.long_thresholds_hi;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time      <= DEBOUNCE_RST;
      cfg_q.short_limit        <= SHORT_MAX_RST;
      cfg_q.long_thresholds_lo <= THR_RST;
      cfg_q.long_thresholds_hi <= THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bpc_lane.sv =====
module bpc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [bpc_pkg::TIME_W-1:0]    now_i,
  input  logic                          level_i,
  input  logic [bpc_pkg::MS_W-1:0]      debounce_i,
  input  logic [bpc_pkg::MS_W-1:0]      short_max_i,
  input  logic [bpc_pkg::MS_W-1:0]      thr_i,
  output logic                          short_o,
  output logic                          long_o
);
  import bpc_pkg::*;

  logic              level_q, level_d;
  logic [TIME_W-1:0] edge_q, edge_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic              held_q, held_d;
  logic              long_q, long_d;

  logic [TIME_W-1:0] since_edge;
  logic [TIME_W-1:0] hold_time;
  logic              changed;
  logic              bounced;

  assign since_edge = now_i - edge_q;
  assign hold_time  = now_i - start_q;
  assign changed    = level_i != level_q;
  assign bounced    = since_edge < {{(TIME_W-MS_W){1'b0}}, debounce_i};

  always_comb begin
    level_d = level_q;
    edge_d  = edge_q;
    start_d = start_q;
    held_d  = held_q;
    long_d  = long_q;
    short_o = 1'b0;
    long_o  = 1'b0;
    if (changed) begin
      // drop an edge that comes too soon after the last accepted one
      if (!bounced) begin
        edge_d  = now_i;
        level_d = level_i;
        if (!level_i) begin
          start_d = now_i;
          held_d  = 1'b1;
          long_d  = 1'b0;
        end else begin
          short_o = held_q & ~long_q &
                    (hold_time < {{(TIME_W-MS_W){1'b0}}, short_max_i});
          start_d = '0;
          held_d  = 1'b0;
        end
      end
    end else if ((thr_i != '0) && !level_i && held_q && !long_q &&
                 (hold_time >= {{(TIME_W-MS_W){1'b0}}, thr_i})) begin
      long_d = 1'b1;
      long_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      edge_q  <= '0;
      start_q <= '0;
      held_q  <= 1'b0;
      long_q  <= 1'b0;
    end else if (step_i) begin
      level_q <= level_d;
      edge_q  <= edge_d;
      start_q <= start_d;
      held_q  <= held_d;
      long_q  <= long_d;
    end
  end

endmodule

// ===== hdl/button_press_classifier.sv =====
// Button press classifier: each scan item (millisecond timestamp plus eight
// active-low levels) yields one result item with a short-press and a
// long-press mask. Edges closer than the debounce time to a button's last
// accepted edge are ignored; a release held under the short-press limit reports
// a short press unless a long press was already reported; a long press is
// reported once when the hold time reaches that button's 16-bit threshold (zero
// turns it off). Timing: an item is registered in the input register on
// acceptance and its result moves to the output register once that register is
// empty or being emptied (two register stages); one item is taken every cycle
// while the output register is not stalled. Buttons at index BUTTONS and above
// are ignored and read as zero in both masks. Registers sit at byte addresses
// 0, 8, 16 and 24 of the 64-bit APB port; write them only while idle.
module button_press_classifier #(
  parameter int unsigned BUTTONS = bpc_pkg::BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bpc_pkg::bpc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bpc_pkg::bpc_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bpc_pkg::*;

  bpc_cfg_t cfg;
  bpc_in_t  in_q;
  logic     in_valid_q;
  bpc_out_t out_q, out_d;
  logic     out_valid_q;
  logic     step;

  logic [2*THR_WORD_W-1:0] thr_all;
  logic [LANES-1:0]        short_bits;
  logic [LANES-1:0]        long_bits;

  bpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance when the input register holds an item and the output register is empty or being emptied
  assign step       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | step;

  assign thr_all = {cfg.long_thresholds_hi, cfg.long_thresholds_lo};

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < BUTTONS) begin : g_used
      bpc_lane u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .step_i      (step),
        .now_i       (in_q.now_ms),
        .level_i     (in_q.button_levels[k]),
        .debounce_i  (cfg.debounce_time),
        .short_max_i (cfg.short_limit),
        .thr_i       (thr_all[MS_W*k +: MS_W]),
        .short_o     (short_bits[k]),
        .long_o      (long_bits[k])
      );
    end else begin : g_unused
      assign short_bits[k] = 1'b0;
      assign long_bits[k]  = 1'b0;
    end
  end

  always_comb begin
    out_d.short_press_mask = short_bits;
    out_d.long_press_mask  = long_bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  localparam int unsigned NUM_BUTTONS     = BUTTONS_DEF;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_ITEMS     = 275;
  localparam int unsigned DRAIN_PAUSE     = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef enum logic {
    ROW_SCAN,
    ROW_WRITE
  } row_kind_e;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_COIN,
    SINK_SPARSE
  } sink_mode_e;

  typedef struct packed {
    row_kind_e         kind;
    bpc_reg_e          reg_sel;
    logic [63:0]       reg_val;
    logic [TIME_W-1:0] now_ms;
    logic [LANES-1:0]  levels;
    logic              typed;
    logic [LANES-1:0]  short_m;
    logic [LANES-1:0]  long_m;
  } plan_row_t;

  // Rows with typed set carry their result; the rest go through the predictor.
  localparam plan_row_t DIRECTED_PLAN [0:25] = '{
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd0,          8'hFF, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd10,         8'h00, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd60,         8'h00, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd100,        8'hFF, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd110,        8'hFF, 1'b1, 8'hFF, 8'h00},
    '{ROW_WRITE, REG_DEBOUNCE,  64'd0, 32'd0,          8'hFF, 1'b0, 8'h00, 8'h00},
    // press at time zero, then a short release
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd0,          8'hFE, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd7,          8'hFF, 1'b1, 8'h01, 8'h00},
    '{ROW_WRITE, REG_THR_LO, 64'h0001_0000_FFFF_0064, 32'd0, 8'hFF, 1'b0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_THR_HI, 64'hFFFF_0002_0001_8000, 32'd0, 8'hFF, 1'b0, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd1000,       8'h00, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd1001,       8'h00, 1'b1, 8'h00, 8'h28},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd1100,       8'h00, 1'b1, 8'h00, 8'h41},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd1100,       8'hFF, 1'b1, 8'h96, 8'h00},
    '{ROW_WRITE, REG_SHORT_MAX, 64'd0, 32'd0,          8'hFF, 1'b0, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd2000,       8'h00, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'd2000,       8'hFF, 1'b1, 8'h00, 8'h00},
    '{ROW_WRITE, REG_SHORT_MAX, 64'hFFFF, 32'd0,       8'hFF, 1'b0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_DEBOUNCE,  64'hFFFF, 32'd0,       8'hFF, 1'b0, 8'h00, 8'h00},
    // time wraps between the press and the release
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'hFFFF_FFF0,  8'h00, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'h0000_0010,  8'hFF, 1'b1, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'h0000_0010,  8'h00, 1'b1, 8'h00, 8'h68},
    '{ROW_WRITE, REG_DEBOUNCE,  64'd0, 32'd0,          8'hFF, 1'b0, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'h0000_0010,  8'hFF, 1'b1, 8'h97, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'hFFFF_FFFF,  8'hAA, 1'b0, 8'h00, 8'h00},
    '{ROW_SCAN,  REG_DEBOUNCE,  64'd0, 32'hFFFF_FFFF,  8'hAA, 1'b0, 8'h00, 8'h00}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  bpc_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  bpc_out_t              out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the block's registers and per-button state
  bpc_cfg_t          shadow_cfg;
  logic [LANES-1:0]  level_seen;
  logic [LANES-1:0]  held_now;
  logic [LANES-1:0]  long_done;
  logic [TIME_W-1:0] edge_ms  [LANES];
  logic [TIME_W-1:0] press_ms [LANES];

  bpc_out_t          press_q [$];
  int unsigned       mismatches;
  int unsigned       cycles;
  bit                hold_off_req;
  logic [TIME_W-1:0] scan_clock;
  logic [LANES-1:0]  scan_levels;

  button_press_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MS_W-1:0] lane_threshold(input int unsigned lane);
    logic [THR_WORD_W-1:0] word;
    word = (lane < 4) ? shadow_cfg.long_thresholds_lo : shadow_cfg.long_thresholds_hi;
    return word[16*(lane%4) +: 16];
  endfunction

  function automatic bpc_out_t classify_scan(input bpc_in_t scan);
    bpc_out_t          res;
    logic              cur;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] hold_ms;
    logic [MS_W-1:0]   thr;
    res = '0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      cur        = scan.button_levels[k];
      since_edge = scan.now_ms - edge_ms[k];
      hold_ms    = scan.now_ms - press_ms[k];
      if (cur != level_seen[k]) begin
        // drop edges inside the debounce window
        if (since_edge >= TIME_W'(shadow_cfg.debounce_time)) begin
          edge_ms[k] = scan.now_ms;
          if (!cur) begin
            press_ms[k]  = scan.now_ms;
            held_now[k]  = 1'b1;
            long_done[k] = 1'b0;
          end else begin
            if (held_now[k] && !long_done[k] &&
                hold_ms < TIME_W'(shadow_cfg.short_limit)) begin
              res.short_press_mask[k] = 1'b1;
            end
            press_ms[k] = '0;
            held_now[k] = 1'b0;
          end
          level_seen[k] = cur;
        end
      end else begin
        thr = lane_threshold(k);
        if (thr != '0 && !cur && held_now[k] && !long_done[k] && hold_ms >= TIME_W'(thr)) begin
          long_done[k]           = 1'b1;
          res.long_press_mask[k] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [MS_W-1:0] pick_ms(input int unsigned typical_hi);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return MS_W'($urandom_range(1, typical_hi));
    endcase
  endfunction

  task automatic offer_scan(input bpc_in_t scan, input bit typed, input bpc_out_t typed_res);
    bpc_out_t pred;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = scan;
    do @(posedge clk_i); while (!in_ready_o);
    pred = classify_scan(scan);
    press_q.push_back(typed ? typed_res : pred);
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (press_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_reg(input bpc_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DEBOUNCE:  shadow_cfg.debounce_time      = val[MS_W-1:0];
      REG_SHORT_MAX: shadow_cfg.short_limit        = val[MS_W-1:0];
      REG_THR_LO:    shadow_cfg.long_thresholds_lo = val;
      REG_THR_HI:    shadow_cfg.long_thresholds_hi = val;
      default: ;
    endcase
  endtask

  initial begin : sink
    sink_mode_e  sink_mode;
    int unsigned mode_left;
    out_ready_i = 1'b0;
    sink_mode   = SINK_STEADY;
    mode_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (sink_mode)
        SINK_STEADY: out_ready_i = 1'b1;
        SINK_COIN:   out_ready_i = 1'($urandom_range(0, 1));
        default:     out_ready_i = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    bpc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (press_q.size() == 0) begin
        $display("%0t: unexpected result item, actual short %h long %h", $time,
                 out_data_o.short_press_mask, out_data_o.long_press_mask);
        mismatches++;
      end else begin
        want = press_q.pop_front();
        if (out_data_o.short_press_mask !== want.short_press_mask) begin
          $display("%0t: short_press_mask expected %h actual %h", $time,
                   want.short_press_mask, out_data_o.short_press_mask);
          mismatches++;
        end
        if (out_data_o.long_press_mask !== want.long_press_mask) begin
          $display("%0t: long_press_mask expected %h actual %h", $time,
                   want.long_press_mask, out_data_o.long_press_mask);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    bpc_in_t     scan;
    bpc_out_t    typed_res;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned step_max;
    int unsigned flip_div;
    int unsigned roll;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_off_req = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    scan_clock   = '0;
    scan_levels  = '1;
    shadow_cfg   = '{DEBOUNCE_RST, SHORT_MAX_RST, THR_RST, THR_RST};
    level_seen   = '1;
    held_now     = '0;
    long_done    = '0;
    for (int k = 0; k < LANES; k++) begin
      edge_ms[k]  = '0;
      press_ms[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(DIRECTED_PLAN[i].reg_sel, DIRECTED_PLAN[i].reg_val);
      end else begin
        scan.now_ms                = DIRECTED_PLAN[i].now_ms;
        scan.button_levels         = DIRECTED_PLAN[i].levels;
        typed_res.short_press_mask = DIRECTED_PLAN[i].short_m;
        typed_res.long_press_mask  = DIRECTED_PLAN[i].long_m;
        offer_scan(scan, DIRECTED_PLAN[i].typed, typed_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(REG_DEBOUNCE, 64'(pick_ms(60)));
      write_reg(REG_SHORT_MAX, 64'(pick_ms(400)));
      write_reg(REG_THR_LO, {pick_ms(300), pick_ms(300), pick_ms(300), pick_ms(300)});
      write_reg(REG_THR_HI, {pick_ms(300), pick_ms(300), pick_ms(300), pick_ms(300)});
      case ($urandom_range(0, 2))
        0:       step_max = 3;
        1:       step_max = 25;
        default: step_max = 90;
      endcase
      case ($urandom_range(0, 2))
        0:       flip_div = 2;
        1:       flip_div = 6;
        default: flip_div = 12;
      endcase
      scan_clock = $urandom;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 40) hold_off_req = 1'b1;
        if (p == 3 && n == 137) drain_results();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 9) < 7) begin
            gap = $urandom_range(1, 8);
            @(negedge clk_i);
            in_valid_i = 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          // noise: jump anywhere in time with arbitrary levels
          scan_clock  = scan_clock + $urandom;
          scan_levels = LANES'($urandom);
        end else begin
          scan_clock = scan_clock + $urandom_range(0, step_max);
          if (roll < 6) scan_clock = scan_clock + $urandom;
          for (int k = 0; k < LANES; k++) begin
            if ($urandom_range(0, flip_div - 1) == 0) scan_levels[k] = ~scan_levels[k];
          end
        end
        scan.now_ms        = scan_clock;
        scan.button_levels = scan_levels;
        offer_scan(scan, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bpc_pkg.sv
hdl/bpc_regs.sv
hdl/bpc_lane.sv
hdl/button_press_classifier.sv
tb/tb_top.sv
